// File: hdl/assert_macros.svh
// Assertion macros shared by the dispatcher RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define GSD_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset.
`define GSD_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/gsd_pkg.sv
// Types, codes and helpers of the guaranteed-share dispatcher.
`default_nettype none

package gsd_pkg;

    // Sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_COMMIT,
        S_EMIT
    } t_state;

    // Item kinds
    localparam logic [1:0] KIND_LOAD     = 2'd0;
    localparam logic [1:0] KIND_DISPATCH = 2'd1;
    localparam logic [1:0] KIND_ADVANCE  = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_LOADED     = 2'd0;
    localparam logic [1:0] ST_DISPATCHED = 2'd1;
    localparam logic [1:0] ST_NONE       = 2'd2;
    localparam logic [1:0] ST_ADVANCED   = 2'd3;

    // Clock add that sticks at all ones
    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [15:0] b);
        logic [32:0] s;
        s = {1'b0, a} + 33'(b);
        return s[32] ? '1 : s[31:0];
    endfunction

endpackage

`default_nettype wire

// File: hdl/guaranteed_share_dispatcher.sv
// Guaranteed-share dispatcher: slot table, clock and scanning cross-multiply chooser.
// A load or advance item goes from idle to the emit state, which loads the result
// register; the next item can be taken after that. A dispatch item walks the slot
// table one slot per cycle through a three-stage pipe (table read, elapsed-time
// subtract, one shared cross-multiply comparator against the running best), waits
// for the pipe to empty and finish the scan, then commits the chosen task in the
// commit state and loads the result register in the emit state; the input stalls
// for all of that time, and longer while a previous result is held by a stalled
// output. The result register lets a finished result wait while the next item is
// taken. A kind code of three is taken and dropped without a result. Ties go to
// the lowest slot, a task with no time elapsed counts as having ratio zero, and
// the clock saturates.
`default_nettype none

module guaranteed_share_dispatcher
    import gsd_pkg::*;
#(
    parameter int SLOTS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input channel
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [1:0]  i_kind,
    input  wire logic [3:0]  i_slot,
    input  wire logic [31:0] i_arrival,
    input  wire logic [15:0] i_burst,
    input  wire logic [15:0] i_advance,
    // result channel
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [1:0]       o_status,
    output logic [3:0]       o_chosen_slot,
    output logic [31:0]      o_start_time,
    output logic [31:0]      o_finish_time
);

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int SW = (IW > 4) ? IW : 4;

    // sequencer
    t_state r_state, n_state;
    logic   accept_in, scan_issue, scan_done, emit_go, commit_clear;

    // slot table
    logic [31:0]      r_arrival_mem [SLOTS];
    logic [15:0]      r_burst_mem   [SLOTS];
    logic [15:0]      r_rem_mem     [SLOTS];
    logic [SLOTS-1:0] r_live;
    logic [31:0]      r_clock;

    logic [SW-1:0] slot_ext;
    logic [IW-1:0] wr_idx, rd_idx, rem_wa;
    logic          slot_ok, load_we, rem_we;
    logic [15:0]   rem_wd;

    // scan pipe
    logic [IW:0]   r_idx;
    logic          r_a_v, r_b_v;
    logic [31:0]   r_a_arr;
    logic [15:0]   r_a_bur, r_a_rem;
    logic          r_a_live;
    logic [IW-1:0] r_a_idx, r_b_idx;
    logic [32:0]   diff;
    logic          b_elig, r_b_elig;
    logic [15:0]   b_h, r_b_h, r_b_rem;
    logic [31:0]   b_t, r_b_t;
    logic [47:0]   p_new, p_old;
    logic          take;

    // running best
    logic          r_found;
    logic [IW-1:0] r_best;
    logic [15:0]   r_best_h, r_best_rem;
    logic [31:0]   r_best_t;
    logic [SW-1:0] best_ext;

    // pending result and output register
    logic [1:0]  r_status;
    logic [3:0]  r_chosen;
    logic [31:0] r_start;
    logic        r_out_valid;
    logic [1:0]  r_o_status;
    logic [3:0]  r_o_chosen;
    logic [31:0] r_o_start, r_o_finish;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept_in) begin
                    case (i_kind)
                        KIND_LOAD:     n_state = S_EMIT;
                        KIND_ADVANCE:  n_state = S_EMIT;
                        KIND_DISPATCH: n_state = S_SCAN;
                        default:       n_state = S_IDLE;
                    endcase
                end
            end
            S_SCAN:   if (scan_done) n_state = S_COMMIT;
            S_COMMIT: n_state = S_EMIT;
            S_EMIT:   if (emit_go) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // control outputs of the sequencer
    always_comb begin
        o_stall      = (r_state != S_IDLE);
        scan_issue   = (r_state == S_SCAN) && (r_idx != (IW+1)'(SLOTS));
        scan_done    = (r_state == S_SCAN) && !scan_issue && !r_a_v && !r_b_v;
        commit_clear = (r_state == S_COMMIT) && r_found;
        emit_go      = (r_state == S_EMIT) && (!r_out_valid || !i_stall);
    end

    assign accept_in = i_valid && !o_stall;

    // load address decode; slots past the table are ignored
    assign slot_ext = SW'(i_slot);
    assign wr_idx   = slot_ext[IW-1:0];
    assign slot_ok  = (32'(i_slot) < 32'(SLOTS));
    assign load_we  = accept_in && (i_kind == KIND_LOAD) && slot_ok;
    assign rd_idx   = r_idx[IW-1:0];

    // remaining-time port: load writes the burst, commit clears the winner
    assign rem_we = load_we || commit_clear;
    assign rem_wa = commit_clear ? r_best : wr_idx;
    assign rem_wd = commit_clear ? 16'd0 : i_burst;

    // arrival and burst memories
    always_ff @(posedge i_clk) begin
        if (load_we) begin
            r_arrival_mem[wr_idx] <= i_arrival;
            r_burst_mem[wr_idx]   <= i_burst;
        end
        if (scan_issue) begin
            r_a_arr <= r_arrival_mem[rd_idx];
            r_a_bur <= r_burst_mem[rd_idx];
        end
    end

    // remaining memory
    always_ff @(posedge i_clk) begin
        if (rem_we) begin
            r_rem_mem[rem_wa] <= rem_wd;
        end
        if (scan_issue) begin
            r_a_rem <= r_rem_mem[rd_idx];
        end
    end

    // live bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live <= '0;
        end else if (load_we) begin
            r_live[wr_idx] <= 1'b1;
        end
    end

    // stage B: eligibility, service received and time elapsed
    always_comb begin
        diff   = {1'b0, r_clock} - {1'b0, r_a_arr};
        b_elig = r_a_live && (r_a_rem != 16'd0) && !diff[32];
        if (diff[31:0] == 32'd0) begin
            b_h = 16'd0;
            b_t = 32'd1;
        end else begin
            b_h = r_a_bur - r_a_rem;
            b_t = diff[31:0];
        end
    end

    // stage C: shared cross-multiply comparator against the running best
    assign p_new = 48'(r_b_h) * 48'(r_best_t);
    assign p_old = 48'(r_best_h) * 48'(r_b_t);
    assign take  = r_b_v && r_b_elig && (!r_found || (p_new < p_old));

    assign best_ext = SW'(r_best);

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_a_v       <= 1'b0;
            r_b_v       <= 1'b0;
            r_found     <= 1'b0;
            r_clock     <= 32'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_a_v   <= scan_issue;
            r_b_v   <= r_a_v;
            if (accept_in && (i_kind == KIND_DISPATCH)) begin
                r_idx   <= '0;
                r_found <= 1'b0;
            end else begin
                if (scan_issue) r_idx <= r_idx + 1'b1;
                if (take) r_found <= 1'b1;
            end
            if (accept_in && (i_kind == KIND_ADVANCE)) begin
                r_clock <= sat_add(r_clock, i_advance);
            end else if (commit_clear) begin
                r_clock <= sat_add(r_clock, r_best_rem);
            end
            if (emit_go) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // scan pipe, best candidate and result payload
    always_ff @(posedge i_clk) begin
        if (scan_issue) begin
            r_a_live <= r_live[rd_idx];
            r_a_idx  <= rd_idx;
        end
        r_b_elig <= b_elig;
        r_b_h    <= b_h;
        r_b_t    <= b_t;
        r_b_rem  <= r_a_rem;
        r_b_idx  <= r_a_idx;
        if (take) begin
            r_best     <= r_b_idx;
            r_best_h   <= r_b_h;
            r_best_t   <= r_b_t;
            r_best_rem <= r_b_rem;
        end
        // pending result
        if (accept_in) begin
            r_status <= (i_kind == KIND_ADVANCE) ? ST_ADVANCED : ST_LOADED;
            r_chosen <= 4'd0;
            r_start  <= 32'd0;
        end else if (r_state == S_COMMIT) begin
            r_status <= r_found ? ST_DISPATCHED : ST_NONE;
            r_chosen <= r_found ? best_ext[3:0] : 4'd0;
            r_start  <= r_found ? r_clock : 32'd0;
        end
        // output register
        if (emit_go) begin
            r_o_status <= r_status;
            r_o_chosen <= r_chosen;
            r_o_start  <= r_start;
            r_o_finish <= r_clock;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_status      = r_o_status;
    assign o_chosen_slot = r_o_chosen;
    assign o_start_time  = r_o_start;
    assign o_finish_time = r_o_finish;

    // checks
`include "assert_macros.svh"

    `GSD_ASSERT_IMP(a_clock_mono, $past(i_rst_n), r_clock >= $past(r_clock), "clock went back")
    `GSD_ASSERT_IMP(a_commit_live, (r_state == S_COMMIT) && r_found,
                    r_best_rem != 16'd0, "finished task chosen")
    `GSD_ASSERT_IMP(a_start_le_finish, o_valid && (o_status == ST_DISPATCHED),
                    o_start_time <= o_finish_time, "start after finish")
    `GSD_ASSERT_NXT(a_scan_to_commit, scan_done, r_state == S_COMMIT, "scan did not commit")

endmodule

`default_nettype wire
